>>> sv/sr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sr_pkg
// Shared types, constants and arithmetic helpers for the reverb core.
// ----------------------------------------------------------------------------
package sr_pkg;

   // The depth must be a power of two, so that address arithmetic wraps by itself.
   localparam int LINE_DEPTH = 32768;
   localparam int LINE_AW    = $clog2(LINE_DEPTH);
   localparam int LINE_SEL_W = 3;
   localparam int MEM_AW     = LINE_AW + LINE_SEL_W;

   localparam int AP_ONE_DELAY   = 5512;
   localparam int AP_TWO_DELAY   = 1852;
   localparam int AP_THREE_DELAY = 529;

   localparam logic [14:0] OFFSET_TWO   = 15'd4293;
   localparam logic [14:0] OFFSET_THREE = 15'd5046;
   localparam logic [14:0] OFFSET_FOUR  = 15'd3604;

   localparam logic [2:0] REG_COMB_DECAY   = 3'd0;
   localparam logic [2:0] REG_ALLPASS_GAIN = 3'd1;
   localparam logic [2:0] REG_DRY_GAIN     = 3'd2;
   localparam logic [2:0] REG_WET_GAIN     = 3'd3;
   localparam logic [2:0] REG_COMB_ONE     = 3'd4;
   localparam logic [2:0] REG_COMB_TWO     = 3'd5;
   localparam logic [2:0] REG_COMB_THREE   = 3'd6;
   localparam logic [2:0] REG_COMB_FOUR    = 3'd7;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_CLEAR, OP_COMB_RD, OP_COMB_MUL, OP_COMB_WR,
      OP_AP_RD, OP_AP_MUL1, OP_AP_WR, OP_AP_MUL2, OP_AP_OUT,
      OP_MIX1, OP_MIX2, OP_MIX3
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
   } status_type;

   typedef struct packed {
      logic [14:0]      comb_decay;
      logic [14:0]      allpass_gain;
      logic [15:0]      dry_gain;
      logic [15:0]      wet_gain;
      logic [3:0][14:0] comb_delay;
   } cfg_type;

   function automatic logic [LINE_AW-1:0] ap_delay(input logic [1:0] idx);
      logic [LINE_AW-1:0] d;
      case (idx)
         2'd0:    d = LINE_AW'(AP_ONE_DELAY);
         2'd1:    d = LINE_AW'(AP_TWO_DELAY);
         default: d = LINE_AW'(AP_THREE_DELAY);
      endcase
      return d;
   endfunction

   function automatic logic [14:0] clamp_gain(input logic [14:0] base,
                                              input logic [14:0] off);
      return (base > off) ? 15'(base - off) : 15'd0;
   endfunction

   // Round a Q15-scaled product to the nearest integer, ties going up.
   function automatic logic signed [26:0] round_q15(input logic signed [41:0] p);
      logic signed [41:0] t;
      t = p + 42'sd16384;
      return t[41:15];
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
      logic signed [23:0] r;
      if (v > 28'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (v < -28'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

endpackage

>>> sv/sr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sr_ctrl
// Sequencer that steps the datapath through combs, all-passes and the mix.
// ----------------------------------------------------------------------------
module sr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  sr_pkg::status_type status,
   output sr_pkg::cmd_type    cmd
);

   typedef enum logic [12:0] {
      ST_CLEAR  = 13'b0000000000001,
      ST_IDLE   = 13'b0000000000010,
      ST_C_RD   = 13'b0000000000100,
      ST_C_MUL  = 13'b0000000001000,
      ST_C_WR   = 13'b0000000010000,
      ST_A_RD   = 13'b0000000100000,
      ST_A_MUL1 = 13'b0000001000000,
      ST_A_WR   = 13'b0000010000000,
      ST_A_MUL2 = 13'b0000100000000,
      ST_A_OUT  = 13'b0001000000000,
      ST_M_MUL1 = 13'b0010000000000,
      ST_M_MUL2 = 13'b0100000000000,
      ST_M_DONE = 13'b1000000000000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      req_ready    = 1'b0;
      cmd.op       = sr_pkg::OP_NONE;
      cmd.idx      = idx_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.op = sr_pkg::OP_CLEAR;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = sr_pkg::OP_LOAD;
               idx_in   = 2'd0;
               state_in = ST_C_RD;
            end
         end
         ST_C_RD: begin
            cmd.op   = sr_pkg::OP_COMB_RD;
            state_in = ST_C_MUL;
         end
         ST_C_MUL: begin
            cmd.op   = sr_pkg::OP_COMB_MUL;
            state_in = ST_C_WR;
         end
         ST_C_WR: begin
            cmd.op = sr_pkg::OP_COMB_WR;
            idx_in = 2'(idx_ff + 2'd1);
            state_in = (idx_ff == 2'd3) ? ST_A_RD : ST_C_RD;
         end
         ST_A_RD: begin
            cmd.op   = sr_pkg::OP_AP_RD;
            state_in = ST_A_MUL1;
         end
         ST_A_MUL1: begin
            cmd.op   = sr_pkg::OP_AP_MUL1;
            state_in = ST_A_WR;
         end
         ST_A_WR: begin
            cmd.op   = sr_pkg::OP_AP_WR;
            state_in = ST_A_MUL2;
         end
         ST_A_MUL2: begin
            cmd.op   = sr_pkg::OP_AP_MUL2;
            state_in = ST_A_OUT;
         end
         ST_A_OUT: begin
            cmd.op = sr_pkg::OP_AP_OUT;
            if (idx_ff == 2'd2) begin
               state_in = ST_M_MUL1;
            end else begin
               idx_in   = 2'(idx_ff + 2'd1);
               state_in = ST_A_RD;
            end
         end
         ST_M_MUL1: begin
            cmd.op   = sr_pkg::OP_MIX1;
            state_in = ST_M_MUL2;
         end
         ST_M_MUL2: begin
            cmd.op   = sr_pkg::OP_MIX2;
            state_in = ST_M_DONE;
         end
         ST_M_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = sr_pkg::OP_MIX3;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> sv/sr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sr_datapath
// Delay-line memory, shared multiplier and accumulators of the reverb core.
// ----------------------------------------------------------------------------
module sr_datapath (
   input  logic               clock,
   input  logic               reset,
   input  sr_pkg::cmd_type    cmd,
   input  sr_pkg::cfg_type    cfg,
   input  logic signed [23:0] req_sample_in,
   output sr_pkg::status_type status,
   output logic signed [23:0] rsp_sample_out
);

   localparam int MEM_DEPTH = 2 ** sr_pkg::MEM_AW;

   logic signed [23:0] mem [MEM_DEPTH];

   logic [sr_pkg::LINE_AW-1:0] wp_ff, wp_in;
   logic [sr_pkg::MEM_AW-1:0]  clr_ff, clr_in;
   logic signed [23:0]         x_ff, rd_ff, v_ff, u_ff, out_ff;
   logic signed [25:0]         sum_ff;
   logic signed [40:0]         prod_ff, acc_ff;

   logic [sr_pkg::LINE_AW-1:0]    delay;
   logic [sr_pkg::LINE_SEL_W-1:0] line;
   logic [sr_pkg::MEM_AW-1:0]     raddr, waddr;
   logic                          rd_en, wr_en;
   logic signed [23:0]            wdata, mul_a, y_comb, v_new, u_new, mix_out;
   logic [15:0]                   mul_b;
   logic [14:0]                   comb_gain;
   logic signed [25:0]            sum_new;
   logic signed [41:0]            mix_sum;

   always_comb begin
      case (cmd.idx)
         2'd0:    comb_gain = cfg.comb_decay;
         2'd1:    comb_gain = sr_pkg::clamp_gain(cfg.comb_decay, sr_pkg::OFFSET_TWO);
         2'd2:    comb_gain = sr_pkg::clamp_gain(cfg.comb_decay, sr_pkg::OFFSET_THREE);
         default: comb_gain = sr_pkg::clamp_gain(cfg.comb_decay, sr_pkg::OFFSET_FOUR);
      endcase
   end

   always_comb begin
      line  = {1'b0, cmd.idx};
      delay = sr_pkg::LINE_AW'(cfg.comb_delay[cmd.idx]);
      rd_en = 1'b0;
      mul_a = rd_ff;
      mul_b = {1'b0, comb_gain};
      case (cmd.op)
         sr_pkg::OP_COMB_RD: rd_en = 1'b1;
         sr_pkg::OP_AP_RD: begin
            rd_en = 1'b1;
            line  = sr_pkg::LINE_SEL_W'(3'd4 + {1'b0, cmd.idx});
            delay = sr_pkg::ap_delay(cmd.idx);
         end
         sr_pkg::OP_AP_MUL1: mul_b = {1'b0, cfg.allpass_gain};
         sr_pkg::OP_AP_MUL2: begin
            mul_a = v_ff;
            mul_b = {1'b0, cfg.allpass_gain};
         end
         sr_pkg::OP_MIX1: begin
            mul_a = x_ff;
            mul_b = cfg.dry_gain;
         end
         sr_pkg::OP_MIX2: begin
            mul_a = u_ff;
            mul_b = cfg.wet_gain;
         end
         default: ;
      endcase
      raddr = {line, sr_pkg::LINE_AW'(wp_ff - delay)};
   end

   assign y_comb  = sr_pkg::sat24(28'(x_ff) + 28'(sr_pkg::round_q15(42'(prod_ff))));
   assign sum_new = 26'(sum_ff + 26'(y_comb));
   assign v_new   = sr_pkg::sat24(28'(u_ff) + 28'(sr_pkg::round_q15(42'(prod_ff))));
   assign u_new   = sr_pkg::sat24(28'(rd_ff) - 28'(sr_pkg::round_q15(42'(prod_ff))));
   assign mix_sum = 42'(acc_ff) + 42'(prod_ff);
   assign mix_out = sr_pkg::sat24(28'(sr_pkg::round_q15(mix_sum)));

   always_comb begin
      wr_en = 1'b0;
      waddr = {{1'b0, cmd.idx}, wp_ff};
      wdata = y_comb;
      case (cmd.op)
         sr_pkg::OP_CLEAR: begin
            wr_en = 1'b1;
            waddr = clr_ff;
            wdata = 24'sd0;
         end
         sr_pkg::OP_COMB_WR: wr_en = 1'b1;
         sr_pkg::OP_AP_WR: begin
            wr_en = 1'b1;
            waddr = {sr_pkg::LINE_SEL_W'(3'd4 + {1'b0, cmd.idx}), wp_ff};
            wdata = v_new;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[waddr] <= wdata;
      if (rd_en) rd_ff <= mem[raddr];
   end

   always_comb begin
      wp_in  = wp_ff;
      clr_in = clr_ff;
      if (cmd.op == sr_pkg::OP_MIX3) wp_in = sr_pkg::LINE_AW'(wp_ff + 1'b1);
      if (cmd.op == sr_pkg::OP_CLEAR) clr_in = sr_pkg::MEM_AW'(clr_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         clr_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op != sr_pkg::OP_NONE) prod_ff <= mul_a * $signed({1'b0, mul_b});
      case (cmd.op)
         sr_pkg::OP_LOAD: begin
            x_ff   <= req_sample_in;
            sum_ff <= 26'sd0;
         end
         sr_pkg::OP_COMB_WR: begin
            sum_ff <= sum_new;
            if (cmd.idx == 2'd3) u_ff <= sr_pkg::sat24(28'(sum_new));
         end
         sr_pkg::OP_AP_WR:  v_ff   <= v_new;
         sr_pkg::OP_AP_OUT: u_ff   <= u_new;
         sr_pkg::OP_MIX2:   acc_ff <= prod_ff;
         sr_pkg::OP_MIX3:   out_ff <= mix_out;
         default: ;
      endcase
   end

   assign status.clear_last = (clr_ff == '1);
   assign rsp_sample_out    = out_ff;

endmodule

>>> sv/schroeder_reverb_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// schroeder_reverb_core
// Four comb filters, three all-pass stages and a dry/wet mix on 24-bit audio.
// ----------------------------------------------------------------------------
// A transaction on the req channel carries one signed 24-bit sample; each one
// yields exactly one transaction on the rsp channel with the mixed sample.
// Both channels use valid/ready handshakes. Registers are written over the
// APB-style port at byte address 4*i and should change only while idle.
// The samples are processed one at a time, and req_ready rises again in the
// cycle after the previous result is registered. The pace is set by the
// single delay-line memory and the one shared multiplier, visited in turn
// by every filter stage.
// A result waits in an output register; the next sample can be accepted and
// processed meanwhile, and the core holds at its final mix step until the
// receiver takes the waiting result.
// After reset the core clears all 262144 delay-line entries, one per cycle,
// with req_ready low; register writes are taken throughout.
// ----------------------------------------------------------------------------
module schroeder_reverb_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [23:0] req_sample_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [23:0] rsp_sample_out,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   sr_pkg::cfg_type    cfg_ff, cfg_in;
   sr_pkg::cmd_type    cmd;
   sr_pkg::status_type status;
   logic               wr_en;
   logic [2:0]         reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            sr_pkg::REG_COMB_DECAY:   cfg_in.comb_decay    = pwdata[14:0];
            sr_pkg::REG_ALLPASS_GAIN: cfg_in.allpass_gain  = pwdata[14:0];
            sr_pkg::REG_DRY_GAIN:     cfg_in.dry_gain      = pwdata[15:0];
            sr_pkg::REG_WET_GAIN:     cfg_in.wet_gain      = pwdata[15:0];
            sr_pkg::REG_COMB_ONE:     cfg_in.comb_delay[0] = pwdata[14:0];
            sr_pkg::REG_COMB_TWO:     cfg_in.comb_delay[1] = pwdata[14:0];
            sr_pkg::REG_COMB_THREE:   cfg_in.comb_delay[2] = pwdata[14:0];
            sr_pkg::REG_COMB_FOUR:    cfg_in.comb_delay[3] = pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         sr_pkg::REG_COMB_DECAY:   prdata = {17'd0, cfg_ff.comb_decay};
         sr_pkg::REG_ALLPASS_GAIN: prdata = {17'd0, cfg_ff.allpass_gain};
         sr_pkg::REG_DRY_GAIN:     prdata = {16'd0, cfg_ff.dry_gain};
         sr_pkg::REG_WET_GAIN:     prdata = {16'd0, cfg_ff.wet_gain};
         sr_pkg::REG_COMB_ONE:     prdata = {17'd0, cfg_ff.comb_delay[0]};
         sr_pkg::REG_COMB_TWO:     prdata = {17'd0, cfg_ff.comb_delay[1]};
         sr_pkg::REG_COMB_THREE:   prdata = {17'd0, cfg_ff.comb_delay[2]};
         default:                  prdata = {17'd0, cfg_ff.comb_delay[3]};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.comb_decay    <= 15'd27427;
         cfg_ff.allpass_gain  <= 15'd22938;
         cfg_ff.dry_gain      <= 16'd0;
         cfg_ff.wet_gain      <= 16'd3277;
         cfg_ff.comb_delay[0] <= 15'd22094;
         cfg_ff.comb_delay[1] <= 15'd29899;
         cfg_ff.comb_delay[2] <= 15'd22535;
         cfg_ff.comb_delay[3] <= 15'd14244;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sr_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .cfg            (cfg_ff),
      .req_sample_in  (req_sample_in),
      .status         (status),
      .rsp_sample_out (rsp_sample_out)
   );

`ifndef SYNTHESIS
   // The clearing pass must follow every reset.
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("req_ready high right after reset");
   // Only one sample is in flight at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction accepted while busy");
   // A new result never overwrites one the receiver has not taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out))
      else $error("pending result lost");
`endif

endmodule

>>> tb/sv/reverb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reverb_checker
// Watches the sample and result channels and the register port of the reverb
// core, predicts every output sample from its own copy of the delay lines and
// registers, and compares each result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module reverb_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [23:0] req_sample_in,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [23:0] rsp_sample_out,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic               pready,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output int                 fail_count,
   output int                 pending,
   output int                 result_count
);

   int unsigned       regs [8];
   int unsigned       wr_ptr;
   int                comb_mem [4][sr_pkg::LINE_DEPTH];
   int                ap_mem   [3][sr_pkg::LINE_DEPTH];
   logic signed [23:0] expected_samples [$];

   function automatic longint sat_24(input longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   function automatic longint rnd_q15(input longint p);
      return (p + 16384) >>> 15;
   endfunction

   function automatic int unsigned tap_index(input int unsigned d);
      int unsigned r;
      r = d % sr_pkg::LINE_DEPTH;
      if (r == 0) r = sr_pkg::LINE_DEPTH;
      return (wr_ptr + sr_pkg::LINE_DEPTH - r) % sr_pkg::LINE_DEPTH;
   endfunction

   function automatic int unsigned reduced_gain(input int unsigned base, input int unsigned off);
      return (base > off) ? base - off : 0;
   endfunction

   function automatic logic signed [23:0] reverb_sample(input logic signed [23:0] x_in);
      longint      x, y, v, vd, u, sum, mix;
      int unsigned gains [4];
      int unsigned apd [3];
      gains[0] = regs[sr_pkg::REG_COMB_DECAY];
      gains[1] = reduced_gain(regs[sr_pkg::REG_COMB_DECAY], sr_pkg::OFFSET_TWO);
      gains[2] = reduced_gain(regs[sr_pkg::REG_COMB_DECAY], sr_pkg::OFFSET_THREE);
      gains[3] = reduced_gain(regs[sr_pkg::REG_COMB_DECAY], sr_pkg::OFFSET_FOUR);
      apd[0] = sr_pkg::AP_ONE_DELAY;
      apd[1] = sr_pkg::AP_TWO_DELAY;
      apd[2] = sr_pkg::AP_THREE_DELAY;
      x = x_in;
      sum = 0;
      for (int k = 0; k < 4; k++) begin
         y = comb_mem[k][tap_index(regs[sr_pkg::REG_COMB_ONE + k])];
         y = sat_24(x + rnd_q15(y * longint'(gains[k])));
         comb_mem[k][wr_ptr] = int'(y);
         sum += y;
      end
      u = sat_24(sum);
      for (int k = 0; k < 3; k++) begin
         vd = ap_mem[k][tap_index(apd[k])];
         v = sat_24(u + rnd_q15(vd * longint'(regs[sr_pkg::REG_ALLPASS_GAIN])));
         ap_mem[k][wr_ptr] = int'(v);
         u = sat_24(vd - rnd_q15(v * longint'(regs[sr_pkg::REG_ALLPASS_GAIN])));
      end
      mix = rnd_q15(x * longint'(regs[sr_pkg::REG_DRY_GAIN])
                    + u * longint'(regs[sr_pkg::REG_WET_GAIN]));
      wr_ptr = (wr_ptr + 1) % sr_pkg::LINE_DEPTH;
      return 24'(sat_24(mix));
   endfunction

   always @(posedge clock) begin
      logic signed [23:0] want;
      int unsigned        idx;
      if (reset) begin
         regs[sr_pkg::REG_COMB_DECAY]   = 27427;
         regs[sr_pkg::REG_ALLPASS_GAIN] = 22938;
         regs[sr_pkg::REG_DRY_GAIN]     = 0;
         regs[sr_pkg::REG_WET_GAIN]     = 3277;
         regs[sr_pkg::REG_COMB_ONE]     = 22094;
         regs[sr_pkg::REG_COMB_TWO]     = 29899;
         regs[sr_pkg::REG_COMB_THREE]   = 22535;
         regs[sr_pkg::REG_COMB_FOUR]    = 14244;
         wr_ptr = 0;
         foreach (comb_mem[k, n]) comb_mem[k][n] = 0;
         foreach (ap_mem[k, n]) ap_mem[k][n] = 0;
         expected_samples.delete();
         fail_count   <= 0;
         pending      <= 0;
         result_count <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            idx = paddr[4:2];
            if (idx == sr_pkg::REG_DRY_GAIN || idx == sr_pkg::REG_WET_GAIN) begin
               regs[idx] = pwdata[15:0];
            end else begin
               regs[idx] = pwdata[14:0];
            end
         end
         if (req_valid && req_ready) expected_samples.push_back(reverb_sample(req_sample_in));
         if (rsp_valid && rsp_ready) begin
            result_count <= result_count + 1;
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected result transaction, actual %0d", $time,
                        rsp_sample_out);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_samples.pop_front();
               if (want !== rsp_sample_out) begin
                  $display("%0t: sample_out mismatch, expected %0d, actual %0d", $time,
                           want, rsp_sample_out);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= expected_samples.size();
      end
   end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the reverb core: directed extremes, then phases of random
// register settings and samples, with random idling on both channels in
// all but the last. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int WATCHDOG_LIMIT = 1000000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [23:0] req_sample_in = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [23:0] rsp_sample_out;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [4:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;
   int                 fail_count, pending, result_count;
   bit                 calm = 1'b0;
   int                 stall_left = 0;
   int                 idle_cycles = 0;
   int                 sent = 0;

   always #4 clock = ~clock;

   schroeder_reverb_core i_dut (.*);

   reverb_checker i_checker (.*);

   always @(negedge clock) begin
      if (calm) begin
         rsp_ready = 1'b1;
      end else if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_ready = 1'b0;
         stall_left = $urandom_range(1, 17) - 1;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input int unsigned value);
      @(negedge clock);
      psel = 1'b1;
      pwrite = 1'b1;
      paddr = {idx, 2'b00};
      pwdata = (value & 32'h0001_FFFF) | ($urandom & 32'hFFFE_0000);
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic write_all(input int unsigned decay, input int unsigned ap_g,
                            input int unsigned dry, input int unsigned wet,
                            input int unsigned d1, input int unsigned d2,
                            input int unsigned d3, input int unsigned d4);
      write_reg(sr_pkg::REG_COMB_DECAY, decay);
      write_reg(sr_pkg::REG_ALLPASS_GAIN, ap_g);
      write_reg(sr_pkg::REG_DRY_GAIN, dry);
      write_reg(sr_pkg::REG_WET_GAIN, wet);
      write_reg(sr_pkg::REG_COMB_ONE, d1);
      write_reg(sr_pkg::REG_COMB_TWO, d2);
      write_reg(sr_pkg::REG_COMB_THREE, d3);
      write_reg(sr_pkg::REG_COMB_FOUR, d4);
   endtask

   task automatic send_sample(input logic signed [23:0] s);
      if (!calm && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 17)) @(negedge clock);
      req_valid = 1'b1;
      req_sample_in = s;
      #1;
      while (!req_ready) begin
         @(negedge clock);
         #1;
      end
      @(negedge clock);
      req_valid = 1'b0;
      sent++;
   endtask

   task automatic drain();
      while (pending != 0 || (sent != result_count)) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   function automatic logic signed [23:0] random_sample();
      case ($urandom_range(0, 5))
         0:       return 24'sh7FFFFF;
         1:       return 24'sh800000;
         2:       return 24'($signed($urandom_range(0, 2000)) - 1000);
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic int unsigned random_gain15();
      case ($urandom_range(0, 4))
         0:       return 0;
         1:       return 32767;
         default: return $urandom_range(0, 32767);
      endcase
   endfunction

   function automatic int unsigned random_gain16();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return 32768;
         2:       return 65535;
         default: return $urandom_range(0, 32768);
      endcase
   endfunction

   function automatic int unsigned random_delay();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return 32767;
         2:       return $urandom_range(1, 32767);
         default: return $urandom_range(1, 64);
      endcase
   endfunction

   initial begin
      logic signed [23:0] directed [12];
      directed = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh000000,
                   -24'sd1, 24'sd1, 24'sh7FFFFF, 24'sh555555, 24'shAAAAAA,
                   24'sh000000, 24'sh000000};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Defaults, then top 15-bit gains, then zero 15-bit and top 16-bit ones.
      foreach (directed[i]) send_sample(directed[i]);
      drain();
      write_all(32767, 32767, 32768, 32768, 1, 2, 3, 4);
      foreach (directed[i]) send_sample(directed[i]);
      drain();
      write_all(0, 0, 65535, 65535, 32767, 0, 1, 5);
      foreach (directed[i]) send_sample(directed[i]);
      drain();

      for (int phase = 0; phase < 7; phase++) begin
         write_all(random_gain15(), random_gain15(), random_gain16(), random_gain16(),
                   random_delay(), random_delay(), random_delay(), random_delay());
         if (phase == 6) calm = 1'b1;
         repeat (195) send_sample(random_sample());
         drain();
      end

      $display("Covered %0d samples over ten register settings, including zero and", sent);
      $display("maximum gains, wrapped delays and saturating inputs.");
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
